@@ rtl/hvd_pkg.sv @@
// Shared types, constants and functions of the HVD parity block scrubber.
// Holds the item structs, parity generation and syndrome scan helpers.
package hvd_pkg;

  // Table geometry
  localparam int unsigned BLOCKS = 128;
  localparam int unsigned AddrW  = $clog2(BLOCKS);
  localparam int unsigned ParW   = 31;

  // Command codes
  localparam logic CmdStore = 1'b0;
  localparam logic CmdCheck = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  block_index;
    logic [63:0] block_data;
  } hvd_in_t;

  typedef struct packed {
    logic [63:0] data_out;
    logic        error_seen;
  } hvd_out_t;

  // Count (saturated at four) and lowest three set positions of a syndrome
  typedef struct packed {
    logic [2:0] n;
    logic [3:0] p0;
    logic [3:0] p1;
    logic [3:0] p2;
  } hvd_pos_t;

  // Row parity in [7:0], column parity in [15:8], anti-diagonal in [30:16]
  function automatic logic [ParW-1:0] block_parity(logic [63:0] w);
    logic [7:0]  hp;
    logic [7:0]  vp;
    logic [14:0] dp;
    hp = '0;
    vp = '0;
    dp = '0;
    for (int r = 0; r < 8; r++) begin
      hp[r] = ^w[8*r +: 8];
      vp    = vp ^ w[8*r +: 8];
      for (int c = 0; c < 8; c++) begin
        dp[r+c] = dp[r+c] ^ w[8*r+c];
      end
    end
    return {dp, vp, hp};
  endfunction

  // Position of the lowest set bit, zero when none
  function automatic logic [3:0] low_pos(logic [14:0] s);
    logic [3:0] p;
    p = '0;
    for (int k = 14; k >= 0; k--) begin
      if (s[k]) p = 4'(k);
    end
    return p;
  endfunction

  function automatic hvd_pos_t scan3(logic [14:0] s);
    logic [14:0] s1;
    logic [14:0] s2;
    logic [14:0] s3;
    hvd_pos_t    res;
    s1 = s & (s - 15'd1);
    s2 = s1 & (s1 - 15'd1);
    s3 = s2 & (s2 - 15'd1);
    res.p0 = low_pos(s);
    res.p1 = low_pos(s1);
    res.p2 = low_pos(s2);
    if (s == '0)       res.n = 3'd0;
    else if (s1 == '0) res.n = 3'd1;
    else if (s2 == '0) res.n = 3'd2;
    else if (s3 == '0) res.n = 3'd3;
    else               res.n = 3'd4;
    return res;
  endfunction

  // One-hot toggle mask for (r, c); empty when outside the block
  function automatic logic [63:0] flip_mask(logic signed [5:0] r, logic signed [5:0] c);
    logic [63:0] m;
    m = '0;
    if (r >= 0 && r < 8 && c >= 0 && c < 8) begin
      m[{r[2:0], c[2:0]}] = 1'b1;
    end
    return m;
  endfunction

endpackage

@@ rtl/hvd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hvd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/hvd_correct.sv @@
// Syndrome decode and bit correction for one 8x8 block.
// Uses hvd_pkg for the syndrome scan and flip mask helpers.
module hvd_correct import hvd_pkg::*; (
  input  logic [63:0]     data_i,
  input  logic [ParW-1:0] syn_i,
  output logic [63:0]     data_o,
  output logic            error_o
);

  hvd_pos_t hs, vs, ds;
  logic signed [5:0] h0, h1, h2, v0, v1, v2, d0, d1, d2;
  logic [8:0]  cnt;
  logic [63:0] mask;

  // Scan the three syndromes
  assign hs = scan3({7'd0, syn_i[7:0]});
  assign vs = scan3({7'd0, syn_i[15:8]});
  assign ds = scan3(syn_i[30:16]);

  assign h0 = $signed({2'b00, hs.p0});
  assign h1 = $signed({2'b00, hs.p1});
  assign h2 = $signed({2'b00, hs.p2});
  assign v0 = $signed({2'b00, vs.p0});
  assign v1 = $signed({2'b00, vs.p1});
  assign v2 = $signed({2'b00, vs.p2});
  assign d0 = $signed({2'b00, ds.p0});
  assign d1 = $signed({2'b00, ds.p1});
  assign d2 = $signed({2'b00, ds.p2});

  assign cnt = {hs.n, vs.n, ds.n};

  // Build the toggle mask from the syndrome weights
  always_comb begin
    mask = '0;
    priority if (cnt == {3'd1, 3'd1, 3'd1}) begin
      if (d0 == h0 + v0) begin
        mask = flip_mask(h0, v0);
      end else if (d0 < h0 + v0) begin
        mask = flip_mask(h0, v0 - 6'sd1) ^ flip_mask(h0 - 6'sd1, v0)
             ^ flip_mask(h0 - 6'sd1, v0 - 6'sd1);
      end else begin
        mask = flip_mask(h0, v0 + 6'sd1) ^ flip_mask(h0 + 6'sd1, v0)
             ^ flip_mask(h0 + 6'sd1, v0 + 6'sd1);
      end
    end else if (cnt == {3'd2, 3'd2, 3'd2}) begin
      if (d0 == h0 + v0) mask = flip_mask(h0, v0) ^ flip_mask(h1, v1);
      else               mask = flip_mask(h1, v0) ^ flip_mask(h0, v1);
    end else if (cnt == {3'd0, 3'd2, 3'd2}) begin
      mask = flip_mask(d0 - v0, v0) ^ flip_mask(d1 - v1, v1);
    end else if (cnt == {3'd2, 3'd0, 3'd2}) begin
      mask = flip_mask(h0, d0 - h0) ^ flip_mask(h1, d1 - h1);
    end else if (cnt == {3'd2, 3'd2, 3'd0}) begin
      mask = flip_mask(h0, v1) ^ flip_mask(h1, v0);
    end else if (cnt == {3'd1, 3'd3, 3'd3}) begin
      mask = flip_mask(h0, v0) ^ flip_mask(h0, v1) ^ flip_mask(h0, v2);
    end else if (cnt == {3'd3, 3'd1, 3'd3}) begin
      mask = flip_mask(h0, v0) ^ flip_mask(h1, v0) ^ flip_mask(h2, v0);
    end else if (cnt == {3'd3, 3'd3, 3'd1}) begin
      mask = flip_mask(h2, v0) ^ flip_mask(h1, v1) ^ flip_mask(h0, v2);
    end else if (cnt == {3'd3, 3'd3, 3'd3}) begin
      if (d0 == h0 + v0 && d1 == h1 + v1 && d2 == h2 + v2) begin
        mask = flip_mask(h0, v0) ^ flip_mask(h1, v1) ^ flip_mask(h2, v2);
      end
    end else begin
      mask = '0;
    end
  end

  assign data_o  = data_i ^ mask;
  assign error_o = (syn_i != '0);

endmodule

@@ rtl/hvd_parity_block_scrubber.sv @@
// HVD parity block scrubber: usage and timing.
// Input channel: in_valid_i / in_stall_o carry one item (cmd, block_index,
// block_data). A store item records the row, column and anti-diagonal
// parities of the block in a 128-entry table; a check item recomputes them,
// forms the syndromes against the stored entry and corrects the block.
// Output channel: out_valid_o / out_stall_i carry one item per input item
// (data_out, error_seen), in input order.
// Path: the input stage and the table read are registered at accept; the
// result then goes to the result register. Throughput: one item per cycle
// while out_stall_i does not hold a waiting result, set by the single-pass
// decode between the input stage and the result register.
// A store updates the table at its accept edge, so a check accepted in the
// next cycle already sees it.
// Reset: asynchronous, active low; both stages empty and every table entry
// reads as zero parity (per-entry valid flags are cleared at once, no
// clearing pass is needed).
// Stall: when out_stall_i holds a waiting result, the input stage holds its
// item and in_stall_o rises only if that stage is also full.
module hvd_parity_block_scrubber import hvd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hvd_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hvd_out_t out_item_o
);

  logic              in_acc;
  logic              in_range;
  logic [AddrW-1:0]  addr;
  logic              tbl_we;
  logic [ParW-1:0]   tbl_rdata;
  logic [BLOCKS-1:0] vld_q;
  logic              s1_valid_q;
  hvd_in_t           s1_item_q;
  logic              s1_hit_q;
  logic              s1_adv;
  logic [ParW-1:0]   stored;
  logic [ParW-1:0]   syn;
  logic [63:0]       fixed_data;
  logic              fixed_err;
  logic              out_valid_q;
  hvd_out_t          out_item_q;
  hvd_out_t          out_item_d;

  // Handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_range = (32'(in_item_i.block_index) < BLOCKS);
  assign addr     = in_item_i.block_index[AddrW-1:0];
  assign tbl_we   = in_acc && (in_item_i.cmd == CmdStore) && in_range;

  // Parity table
  hvd_ram #(
    .Width (ParW),
    .Depth (BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (addr),
    .wdata_i (block_parity(in_item_i.block_data)),
    .re_i    (in_acc),
    .raddr_i (addr),
    .rdata_o (tbl_rdata)
  );

  // Entry written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (tbl_we) begin
      vld_q[addr] <= 1'b1;
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item_i;
      s1_hit_q  <= in_range && vld_q[addr];
    end
  end

  // Syndrome and correction
  assign stored = s1_hit_q ? tbl_rdata : '0;
  assign syn    = stored ^ block_parity(s1_item_q.block_data);

  hvd_correct u_correct (
    .data_i  (s1_item_q.block_data),
    .syn_i   (syn),
    .data_o  (fixed_data),
    .error_o (fixed_err)
  );

  always_comb begin
    if (s1_item_q.cmd == CmdCheck) begin
      out_item_d.data_out   = fixed_data;
      out_item_d.error_seen = fixed_err;
    end else begin
      out_item_d.data_out   = s1_item_q.block_data;
      out_item_d.error_seen = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/hvd_checker.sv @@
// Port-level checks for the HVD parity block scrubber.
// Uses hvd_pkg item types; bound to hvd_parity_block_scrubber below.
module hvd_checker import hvd_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input hvd_in_t  in_item_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input hvd_out_t out_item_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  // Input stall only comes from a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output path free");

  // A newly raised result valid follows an accepted input item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result item without matching input item");

  // Nothing is shown right after reset
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind hvd_parity_block_scrubber hvd_checker u_hvd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

@@ sim/tb_hvd_parity_block_scrubber.sv @@
// Self-checking testbench for hvd_parity_block_scrubber: directed table plus random scrub traffic.
// Depends on hvd_pkg for the item structs and command codes, and on the RTL top level only.
module tb_hvd_parity_block_scrubber;
  import hvd_pkg::*;

  localparam int ITEMS        = 2000;
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  // One row of the directed table; typed rows carry their expected item
  typedef struct packed {
    logic        cmd;
    logic [6:0]  idx;
    logic [63:0] data;
    logic        typed;
    logic [63:0] exp_data;
    logic        exp_err;
  } dir_row_t;

  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // clean check right after reset, then all-ones store and check at the top entry
    '{CmdCheck, 7'd0,   64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000, 1'b0},
    '{CmdStore, 7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    '{CmdCheck, 7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
    // single corner bit lost from the all-ones block
    '{CmdCheck, 7'd127, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1},
    '{CmdStore, 7'd0,   64'h0000_0000_0000_0000, 1'b1, 64'h0000_0000_0000_0000, 1'b0},
    // single bit error against a zero entry
    '{CmdCheck, 7'd2,   64'h0000_0000_1000_0000, 1'b1, 64'h0000_0000_0000_0000, 1'b1},
    // one-one-one, diagonal below and above the crossing
    '{CmdCheck, 7'd3,   64'h0000_0000_0002_0600, 1'b0, 64'h0, 1'b0},
    '{CmdCheck, 7'd4,   64'h0000_0018_1000_0000, 1'b0, 64'h0, 1'b0},
    // neighbor flips that fall outside the block
    '{CmdCheck, 7'd5,   64'h0000_0000_0000_0307, 1'b0, 64'h0, 1'b0},
    // two-two-two, matched and crossed
    '{CmdCheck, 7'd6,   64'h0000_0000_1000_0200, 1'b0, 64'h0, 1'b0},
    '{CmdCheck, 7'd7,   64'h0000_0000_0400_2000, 1'b0, 64'h0, 1'b0},
    // two errors in one row, in one column, on one anti-diagonal
    '{CmdCheck, 7'd8,   64'h0000_0000_0022_0000, 1'b0, 64'h0, 1'b0},
    '{CmdCheck, 7'd9,   64'h0008_0000_0000_0800, 1'b0, 64'h0, 1'b0},
    '{CmdCheck, 7'd10,  64'h0000_0000_0400_1000, 1'b0, 64'h0, 1'b0},
    // three errors in one row, one column, one anti-diagonal
    '{CmdCheck, 7'd11,  64'h0000_0049_0000_0000, 1'b0, 64'h0, 1'b0},
    '{CmdCheck, 7'd12,  64'h2000_0000_0020_0020, 1'b0, 64'h0, 1'b0},
    '{CmdCheck, 7'd13,  64'h0002_0008_0020_0000, 1'b0, 64'h0, 1'b0},
    // three scattered errors, diagonals agreeing and not
    '{CmdCheck, 7'd14,  64'h0000_8000_0400_0001, 1'b0, 64'h0, 1'b0},
    '{CmdCheck, 7'd15,  64'h0000_0400_0200_0040, 1'b0, 64'h0, 1'b0},
    // four scattered errors: no pattern matches
    '{CmdCheck, 7'd16,  64'h0000_0000_4010_0401, 1'b0, 64'h0, 1'b0},
    // stored nonzero entry, then one bit off
    '{CmdStore, 7'd64,  64'h0123_4567_89AB_CDEF, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b0},
    '{CmdCheck, 7'd64,  64'h0123_4467_89AB_CDEF, 1'b0, 64'h0, 1'b0},
    '{CmdCheck, 7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 1'b0}
  };

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  hvd_in_t  in_item_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  hvd_out_t out_item_o;

  // Predictor state: table copy and the last clean block stored per entry
  logic [ParW-1:0] parity_copy [BLOCKS];
  logic [63:0]     clean_block [BLOCKS];
  hvd_out_t        pending_results [$];

  int          err_cnt       = 0;
  int          send_idle_pct = 23;
  int          rx_stall_pct  = 52;
  bit          hold_req      = 1'b0;
  int          hold_left     = 0;
  int unsigned cycle_cnt     = 0;

  hvd_parity_block_scrubber u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Row, column and anti-diagonal parity of a block, rows in the low bits
  function automatic logic [ParW-1:0] calc_parity(logic [63:0] w);
    logic [7:0]  rows;
    logic [7:0]  cols;
    logic [14:0] diags;
    rows  = '0;
    cols  = '0;
    diags = '0;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) begin
        rows[i / 8]          ^= 1'b1;
        cols[i % 8]          ^= 1'b1;
        diags[i / 8 + i % 8] ^= 1'b1;
      end
    end
    return {diags, cols, rows};
  endfunction

  // Count the set bits and record the three lowest positions
  function automatic void find_set(input logic [14:0] s, output int cnt,
                                   output int p0, output int p1, output int p2);
    cnt = 0;
    p0  = 0;
    p1  = 0;
    p2  = 0;
    for (int k = 0; k < 15; k++) begin
      if (s[k]) begin
        if (cnt == 0) p0 = k;
        if (cnt == 1) p1 = k;
        if (cnt == 2) p2 = k;
        cnt++;
      end
    end
  endfunction

  // Toggle one cell; skip anything outside the 8x8 block
  function automatic void toggle_cell(inout logic [63:0] w, input int r, input int c);
    if (r >= 0 && r < 8 && c >= 0 && c < 8) w[8*r + c] = ~w[8*r + c];
  endfunction

  // Expected result of one item; a store updates the table copy.
  // The index is 7 bits wide, so it always lands inside the 128-entry table.
  function automatic hvd_out_t scrub_block(hvd_in_t it);
    logic [63:0]     w;
    logic [ParW-1:0] syn;
    int              hn, vn, dn;
    int              h [3];
    int              v [3];
    int              d [3];
    hvd_out_t        res;
    w   = it.block_data;
    res = '{data_out: w, error_seen: 1'b0};
    if (it.cmd == CmdStore) begin
      parity_copy[it.block_index] = calc_parity(w);
      return res;
    end
    syn = parity_copy[it.block_index] ^ calc_parity(w);
    if (syn == '0) return res;
    find_set({7'b0, syn[7:0]}, hn, h[0], h[1], h[2]);
    find_set({7'b0, syn[15:8]}, vn, v[0], v[1], v[2]);
    find_set(syn[30:16], dn, d[0], d[1], d[2]);
    if (hn == 1 && vn == 1 && dn == 1) begin
      if (d[0] == h[0] + v[0]) begin
        toggle_cell(w, h[0], v[0]);
      end else if (d[0] < h[0] + v[0]) begin
        toggle_cell(w, h[0], v[0] - 1);
        toggle_cell(w, h[0] - 1, v[0]);
        toggle_cell(w, h[0] - 1, v[0] - 1);
      end else begin
        toggle_cell(w, h[0], v[0] + 1);
        toggle_cell(w, h[0] + 1, v[0]);
        toggle_cell(w, h[0] + 1, v[0] + 1);
      end
    end else if (hn == 2 && vn == 2 && dn == 2) begin
      if (d[0] == h[0] + v[0]) begin
        toggle_cell(w, h[0], v[0]);
        toggle_cell(w, h[1], v[1]);
      end else begin
        toggle_cell(w, h[1], v[0]);
        toggle_cell(w, h[0], v[1]);
      end
    end else if (hn == 0 && vn == 2 && dn == 2) begin
      toggle_cell(w, d[0] - v[0], v[0]);
      toggle_cell(w, d[1] - v[1], v[1]);
    end else if (hn == 2 && vn == 0 && dn == 2) begin
      toggle_cell(w, h[0], d[0] - h[0]);
      toggle_cell(w, h[1], d[1] - h[1]);
    end else if (hn == 2 && vn == 2 && dn == 0) begin
      toggle_cell(w, h[0], v[1]);
      toggle_cell(w, h[1], v[0]);
    end else if (hn == 1 && vn == 3 && dn == 3) begin
      for (int k = 0; k < 3; k++) toggle_cell(w, h[0], v[k]);
    end else if (hn == 3 && vn == 1 && dn == 3) begin
      for (int k = 0; k < 3; k++) toggle_cell(w, h[k], v[0]);
    end else if (hn == 3 && vn == 3 && dn == 1) begin
      for (int k = 0; k < 3; k++) toggle_cell(w, h[2-k], v[k]);
    end else if (hn == 3 && vn == 3 && dn == 3) begin
      if (d[0] == h[0] + v[0] && d[1] == h[1] + v[1] && d[2] == h[2] + v[2]) begin
        for (int k = 0; k < 3; k++) toggle_cell(w, h[k], v[k]);
      end
    end
    res.data_out   = w;
    res.error_seen = 1'b1;
    return res;
  endfunction

  // Offer one item after a random gap, hold it until accepted, log its expectation
  task automatic send_item(input hvd_in_t it, input bit typed, input hvd_out_t typed_res);
    hvd_out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = scrub_block(it);
    pending_results.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  // Receiver: random stall, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    hvd_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item data_out=%h error_seen=%b",
                 $time, out_item_o.data_out, out_item_o.error_seen);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.data_out !== want.data_out) begin
          $display("%0t: data_out expected %h actual %h",
                   $time, want.data_out, out_item_o.data_out);
          err_cnt++;
        end
        if (out_item_o.error_seen !== want.error_seen) begin
          $display("%0t: error_seen expected %b actual %b",
                   $time, want.error_seen, out_item_o.error_seen);
          err_cnt++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("hvd_parity_block_scrubber regression: fail");
      $finish;
    end
  end

  initial begin
    hvd_in_t     it;
    hvd_out_t    typed_res;
    logic [63:0] fault;
    int          idx;
    int          pick;
    int          r;
    int          c;
    for (int i = 0; i < BLOCKS; i++) begin
      parity_copy[i] = '0;
      clean_block[i] = '0;
    end
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      it        = '{cmd: DIR_TABLE[i].cmd, block_index: DIR_TABLE[i].idx,
                    block_data: DIR_TABLE[i].data};
      typed_res = '{data_out: DIR_TABLE[i].exp_data, error_seen: DIR_TABLE[i].exp_err};
      if (DIR_TABLE[i].cmd == CmdStore) clean_block[DIR_TABLE[i].idx] = DIR_TABLE[i].data;
      send_item(it, DIR_TABLE[i].typed, typed_res);
    end

    // Random scrub traffic: stores, checks of stored blocks with faults, and noise
    for (int n = 0; n < ITEMS; n++) begin
      if (n == ITEMS / 3) begin
        send_idle_pct = 52;
        rx_stall_pct  = 23;
      end
      if (n == 2 * ITEMS / 3) begin
        // Pause the sender until every result is back, then run flat out into a hold-off
        in_valid_i <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk_i);
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        hold_req      = 1'b1;
      end
      idx  = $urandom_range(BLOCKS - 1);
      pick = $urandom_range(99);
      it.block_index = 7'(idx);
      if (pick < 30) begin
        it.cmd = CmdStore;
        case ($urandom_range(9))
          0:       it.block_data = '0;
          1:       it.block_data = '1;
          default: it.block_data = {$urandom, $urandom};
        endcase
        clean_block[idx] = it.block_data;
      end else if (pick < 85) begin
        fault = '0;
        case ($urandom_range(7))
          0: fault = '0;
          1: fault[$urandom_range(63)] = 1'b1;
          2: begin
            fault[$urandom_range(63)] = 1'b1;
            fault[$urandom_range(63)] = 1'b1;
          end
          3: begin
            for (int k = 0; k < 3; k++) fault[$urandom_range(63)] = 1'b1;
          end
          4: begin
            r = $urandom_range(7);
            fault[8*r +: 8] = 8'($urandom_range(255));
          end
          5: begin
            c = $urandom_range(7);
            for (int k = 0; k < 8; k++) fault[8*k + c] = 1'($urandom_range(1));
          end
          6: begin
            // Scatter along one anti-diagonal
            pick = $urandom_range(14);
            for (int k = 0; k < 8; k++) begin
              if (pick - k >= 0 && pick - k < 8) fault[8*k + pick - k] = 1'($urandom_range(1));
            end
          end
          default: fault = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        it.cmd        = CmdCheck;
        it.block_data = clean_block[idx] ^ fault;
      end else begin
        it.cmd        = CmdCheck;
        it.block_data = {$urandom, $urandom};
      end
      send_item(it, 1'b0, '0);
    end

    // Drain and report
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("hvd_parity_block_scrubber regression: pass");
    end else begin
      $display("hvd_parity_block_scrubber regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hvd_pkg.sv
rtl/hvd_ram.sv
rtl/hvd_correct.sv
rtl/hvd_parity_block_scrubber.sv
rtl/hvd_checker.sv
sim/tb_hvd_parity_block_scrubber.sv
